// ----- sv/ivs_pkg.sv -----
// ivs_pkg: shared types and constants for the indexed value stack
// request opcodes, status codes, fixed port widths and parameter defaults
// no dependencies
`timescale 1ns / 1ps

package ivs_pkg;

   localparam int DATA_W   = 64;
   localparam int INDEX_W  = 12;
   localparam int COUNT_W  = 11;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   localparam int DEF_DEPTH       = 1024;
   localparam int DEF_BLOCK       = 64;
   localparam int DEF_VALUE_WIDTH = 64;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH     = 3'd0,
      MODE_POP      = 3'd1,
      MODE_GET      = 3'd2,
      MODE_POP_MANY = 3'd3,
      MODE_EXTEND   = 3'd4,
      MODE_COLLAPSE = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

// ----- sv/ivs_ram.sv -----
// ivs_ram: generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ivs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ivs_ctrl.sv -----
// ivs_ctrl: stack counters, address generation and response registers
// depends on ivs_pkg; drives the single port of ivs_ram
`timescale 1ns / 1ps

module ivs_ctrl import ivs_pkg::*; #(
   parameter int DEPTH       = DEF_DEPTH,
   parameter int BLOCK       = DEF_BLOCK,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   localparam int AW         = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [DATA_W-1:0]          req_push_value,
   input  logic signed [INDEX_W-1:0]  req_index,
   input  logic [COUNT_W-1:0]         req_count,
   output logic                       ram_wr_en,
   output logic [AW-1:0]              ram_addr,
   output logic [VALUE_WIDTH-1:0]     ram_wr_data,
   input  logic [VALUE_WIDTH-1:0]     ram_rd_data,
   output logic                       rsp_valid,
   output logic [DATA_W-1:0]          rsp_read_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_removed,
   output logic [COUNT_W-1:0]         rsp_used_now,
   output logic [COUNT_W-1:0]         rsp_capacity_now
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int EW = (CW > INDEX_W + 1) ? CW : INDEX_W + 1;

   logic [CW-1:0]      used_ff, used_in;
   logic [CW-1:0]      cap_ff, cap_in;
   logic               rsp_valid_ff;
   logic               rd_ok_ff, rd_ok_in;
   status_type         status_ff, status_in;
   logic [CW-1:0]      removed_ff, removed_in;

   logic signed [EW:0] idx_ext;
   logic [EW:0]        idx_mag;
   logic [EW:0]        used_ext;
   logic [EW:0]        count_ext;
   logic [EW:0]        pos_addr;
   logic [EW:0]        neg_addr;
   logic [SW-1:0]      cap_sw;
   logic [SW-1:0]      used_sw;
   logic [SW-1:0]      block_sw;
   logic [SW-1:0]      depth_sw;
   logic [CW+COUNT_W-1:0] used_wide;
   logic [CW+COUNT_W-1:0] cap_wide;
   logic [CW+COUNT_W-1:0] removed_wide;

   always_comb begin
      idx_ext   = (EW+1)'(req_index);
      idx_mag   = -idx_ext;
      used_ext  = (EW+1)'(used_ff);
      count_ext = (EW+1)'(req_count);
      pos_addr  = idx_ext - (EW+1)'(1);
      neg_addr  = used_ext + idx_ext;
      cap_sw    = SW'(cap_ff);
      used_sw   = SW'(used_ff);
      block_sw  = SW'(BLOCK);
      depth_sw  = SW'(DEPTH);

      used_in     = used_ff;
      cap_in      = cap_ff;
      rd_ok_in    = 1'b0;
      status_in   = STATUS_OK;
      removed_in  = '0;
      ram_wr_en   = 1'b0;
      ram_addr    = used_ff[AW-1:0];
      ram_wr_data = req_push_value[VALUE_WIDTH-1:0];

      case (mode_type'(req_mode))
         MODE_PUSH: begin
            if (used_ff < cap_ff && used_sw < depth_sw) begin
               ram_wr_en = accept;
               used_in   = used_ff + CW'(1);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         MODE_POP: begin
            ram_addr = AW'(used_ff - CW'(1));
            if (used_ff != '0) begin
               rd_ok_in = 1'b1;
               used_in  = used_ff - CW'(1);
            end else begin
               status_in = STATUS_EMPTY;
            end
         end
         MODE_GET: begin
            if (idx_ext > 0 && idx_ext <= $signed(used_ext)) begin
               ram_addr = pos_addr[AW-1:0];
               rd_ok_in = 1'b1;
            end else if (idx_ext < 0 && idx_mag <= used_ext) begin
               ram_addr = neg_addr[AW-1:0];
               rd_ok_in = 1'b1;
            end else begin
               status_in = STATUS_EMPTY;
            end
         end
         MODE_POP_MANY: begin
            if (count_ext < used_ext) begin
               removed_in = count_ext[CW-1:0];
            end else begin
               removed_in = used_ff;
            end
            used_in = used_ff - removed_in;
         end
         MODE_EXTEND: begin
            if (cap_sw + block_sw <= depth_sw) begin
               cap_in = CW'(cap_sw + block_sw);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         MODE_COLLAPSE: begin
            if (cap_sw >= block_sw && cap_sw - block_sw >= used_sw) begin
               cap_in = CW'(cap_sw - block_sw);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            used_ff <= used_in;
            cap_ff  <= cap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ok_ff   <= rd_ok_in;
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   always_comb begin
      used_wide    = {{COUNT_W{1'b0}}, used_ff};
      cap_wide     = {{COUNT_W{1'b0}}, cap_ff};
      removed_wide = {{COUNT_W{1'b0}}, removed_ff};
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rd_ok_ff ? DATA_W'(ram_rd_data) : '0;
   assign rsp_status       = status_ff;
   assign rsp_removed      = removed_wide[COUNT_W-1:0];
   assign rsp_used_now     = used_wide[COUNT_W-1:0];
   assign rsp_capacity_now = cap_wide[COUNT_W-1:0];

endmodule

// ----- sv/indexed_value_stack.sv -----
// indexed_value_stack: operand stack in one flat ram, capacity in blocks
// the result strobe comes in the cycle after the request is accepted
// throughput: one request per cycle; each request uses the single ram port once
// busy stays low; the result receiver cannot stall and needs none
// reset clears used count and capacity; ram contents are undefined until pushed
// depends on ivs_pkg, ivs_ctrl, ivs_ram
`timescale 1ns / 1ps

module indexed_value_stack import ivs_pkg::*; #(
   parameter int DEPTH       = DEF_DEPTH,
   parameter int BLOCK       = DEF_BLOCK,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [DATA_W-1:0]          req_push_value,
   input  logic signed [INDEX_W-1:0]  req_index,
   input  logic [COUNT_W-1:0]         req_count,
   output logic                       rsp_valid,
   output logic [DATA_W-1:0]          rsp_read_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_removed,
   output logic [COUNT_W-1:0]         rsp_used_now,
   output logic [COUNT_W-1:0]         rsp_capacity_now
);

   localparam int AW = $clog2(DEPTH);

   logic                   accept;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   ivs_ctrl #(
      .DEPTH       (DEPTH),
      .BLOCK       (BLOCK),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .req_index        (req_index),
      .req_count        (req_count),
      .ram_wr_en        (ram_wr_en),
      .ram_addr         (ram_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_data      (ram_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_removed      (rsp_removed),
      .rsp_used_now     (rsp_used_now),
      .rsp_capacity_now (rsp_capacity_now)
   );

   ivs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- tb/tb_indexed_value_stack.sv -----
// tb_indexed_value_stack: self-checking bench for the indexed value stack
// directed corners, a capacity sweep up to depth and random request traffic, with a local stack predictor
// depends on ivs_pkg and indexed_value_stack
`timescale 1ns / 1ps

module tb_indexed_value_stack;
   import ivs_pkg::*;

   localparam int DEPTH        = DEF_DEPTH;
   localparam int BLOCK        = DEF_BLOCK;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_ITEMS = 135;

   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct {
      logic [DATA_W-1:0]  read_value;
      status_type         status;
      logic [COUNT_W-1:0] removed;
      logic [COUNT_W-1:0] used_now;
      logic [COUNT_W-1:0] capacity_now;
   } stack_result_type;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      start          = 1'b0;
   logic                      busy;
   logic [MODE_W-1:0]         req_mode       = '0;
   logic [DATA_W-1:0]         req_push_value = '0;
   logic signed [INDEX_W-1:0] req_index      = '0;
   logic [COUNT_W-1:0]        req_count      = '0;
   logic                      rsp_valid;
   logic [DATA_W-1:0]         rsp_read_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [COUNT_W-1:0]        rsp_removed;
   logic [COUNT_W-1:0]        rsp_used_now;
   logic [COUNT_W-1:0]        rsp_capacity_now;

   // predictor state
   logic [DATA_W-1:0] model_values [DEPTH];
   int                model_used     = 0;
   int                model_capacity = 0;

   stack_result_type pending_results [$];
   int               sender_idle_pct = 0;
   int               request_count   = 0;
   int               checked_count   = 0;
   int               mismatch_count  = 0;
   int               quiet_cycles    = 0;

   indexed_value_stack #(
      .DEPTH       (DEPTH),
      .BLOCK       (BLOCK),
      .VALUE_WIDTH (DEF_VALUE_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .req_index        (req_index),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_removed      (rsp_removed),
      .rsp_used_now     (rsp_used_now),
      .rsp_capacity_now (rsp_capacity_now)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic stack_result_type apply_stack_op(input logic [MODE_W-1:0] mode,
                                                       input logic [DATA_W-1:0] value,
                                                       input logic signed [INDEX_W-1:0] index,
                                                       input logic [COUNT_W-1:0] count);
      stack_result_type r;
      int pos;
      int span;
      r.read_value = '0;
      r.status     = STATUS_OK;
      r.removed    = '0;
      pos          = int'(index);
      case (mode)
         MODE_PUSH: begin
            if (model_used < model_capacity && model_used < DEPTH) begin
               model_values[model_used] = value;
               model_used++;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         MODE_POP: begin
            if (model_used > 0) begin
               r.read_value = model_values[model_used - 1];
               model_used--;
            end else begin
               r.status = STATUS_EMPTY;
            end
         end
         MODE_GET: begin
            if (pos > 0 && pos <= model_used) begin
               r.read_value = model_values[pos - 1];
            end else if (pos < 0 && -pos <= model_used) begin
               // k-th from the top sits at slot used - k
               r.read_value = model_values[model_used + pos];
            end else begin
               r.status = STATUS_EMPTY;
            end
         end
         MODE_POP_MANY: begin
            span = (int'(count) < model_used) ? int'(count) : model_used;
            r.removed = COUNT_W'(span);
            model_used -= span;
         end
         MODE_EXTEND: begin
            if (model_capacity + BLOCK <= DEPTH) model_capacity += BLOCK;
            else r.status = STATUS_FULL;
         end
         MODE_COLLAPSE: begin
            if (model_capacity >= BLOCK && model_capacity - BLOCK >= model_used)
               model_capacity -= BLOCK;
            else
               r.status = STATUS_FULL;
         end
         default: begin
         end
      endcase
      r.used_now     = COUNT_W'(model_used);
      r.capacity_now = COUNT_W'(model_capacity);
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic signed [INDEX_W-1:0] rand_index();
      return INDEX_W'($urandom);
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      return COUNT_W'($urandom);
   endfunction

   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [DATA_W-1:0] value,
                               input logic signed [INDEX_W-1:0] index,
                               input logic [COUNT_W-1:0] count);
      start          <= 1'b1;
      req_mode       <= mode;
      req_push_value <= value;
      req_index      <= index;
      req_count      <= count;
      @(posedge clock);
      while (busy) @(posedge clock);
      request_count++;
      pending_results.push_back(apply_stack_op(mode, value, index, count));
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic test_empty_and_refusals();
      sender_idle_pct = 0;
      send_request(MODE_POP, rand_value(), rand_index(), rand_count());
      send_request(MODE_GET, rand_value(), 12'sd0, rand_count());
      send_request(MODE_GET, rand_value(), 12'sd1, rand_count());
      send_request(MODE_GET, rand_value(), -12'sd1, rand_count());
      send_request(MODE_PUSH, '1, rand_index(), rand_count());
      send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
      send_request(MODE_POP_MANY, rand_value(), rand_index(), '1);
      send_request(MODE_SPARE_6, '1, '1, '1);
      send_request(MODE_SPARE_7, '0, '0, '0);
   endtask

   task automatic test_basic_ops();
      sender_idle_pct = 0;
      send_request(MODE_EXTEND, rand_value(), rand_index(), rand_count());
      send_request(MODE_PUSH, '0, rand_index(), rand_count());
      send_request(MODE_PUSH, '1, rand_index(), rand_count());
      send_request(MODE_PUSH, 64'h5555_aaaa_0f0f_f0f0, rand_index(), rand_count());
      send_request(MODE_GET, '0, 12'sd1, '0);
      send_request(MODE_GET, '0, -12'sd1, '0);
      send_request(MODE_GET, '0, 12'sd3, '0);
      send_request(MODE_GET, '0, -12'sd3, '0);
      send_request(MODE_GET, '0, 12'sd4, '0);
      send_request(MODE_GET, '0, -12'sd4, '0);
      send_request(MODE_GET, '0, 12'sd2047, '0);
      send_request(MODE_GET, '0, -12'sd2048, '0);
      send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
      send_request(MODE_SPARE_7, '1, '1, '1);
      send_request(MODE_POP, rand_value(), rand_index(), rand_count());
      send_request(MODE_POP_MANY, rand_value(), rand_index(), 11'd1);
      send_request(MODE_POP_MANY, rand_value(), rand_index(), 11'd0);
      send_request(MODE_POP_MANY, rand_value(), rand_index(), 11'd2047);
   endtask

   task automatic test_capacity_sweep();
      sender_idle_pct = 26;
      send_request(MODE_POP_MANY, rand_value(), rand_index(), '1);
      while (model_capacity + BLOCK <= DEPTH)
         send_request(MODE_EXTEND, rand_value(), rand_index(), rand_count());
      send_request(MODE_EXTEND, rand_value(), rand_index(), rand_count());
      while (model_used < 2 * BLOCK)
         send_request(MODE_PUSH, rand_value(), rand_index(), rand_count());
      while (model_capacity - BLOCK >= model_used)
         send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
      send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
      send_request(MODE_PUSH, rand_value(), rand_index(), rand_count());
      send_request(MODE_GET, '0, INDEX_W'(2 * BLOCK), '0);
      send_request(MODE_GET, '0, INDEX_W'(-2 * BLOCK), '0);
      send_request(MODE_GET, '0, INDEX_W'(2 * BLOCK + 1), '0);
      send_request(MODE_GET, '0, INDEX_W'(-(2 * BLOCK + 1)), '0);
      send_request(MODE_POP_MANY, rand_value(), rand_index(), 11'd1024);
      while (model_capacity >= BLOCK)
         send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
      send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
   endtask

   task automatic test_random_traffic(input int n, input int idle_pct);
      int pick;
      int k;
      logic signed [INDEX_W-1:0] idx;
      logic [COUNT_W-1:0] cnt;
      sender_idle_pct = idle_pct;
      repeat (n) begin
         pick = $urandom_range(99);
         // no room left: usually grow first
         if (model_used == model_capacity && $urandom_range(1) == 1) pick = 0;
         if (pick < 7) begin
            send_request(MODE_EXTEND, rand_value(), rand_index(), rand_count());
         end else if (pick < 13) begin
            send_request(MODE_COLLAPSE, rand_value(), rand_index(), rand_count());
         end else if (pick < 43) begin
            send_request(MODE_PUSH, rand_value(), rand_index(), rand_count());
         end else if (pick < 57) begin
            send_request(MODE_POP, rand_value(), rand_index(), rand_count());
         end else if (pick < 82) begin
            k = $urandom_range(99);
            if (k < 70 && model_used > 0) begin
               k = $urandom_range(1, model_used);
               idx = INDEX_W'(($urandom_range(1) == 1) ? -k : k);
            end else if (k < 80) begin
               idx = '0;
            end else begin
               idx = rand_index();
            end
            send_request(MODE_GET, rand_value(), idx, rand_count());
         end else if (pick < 94) begin
            if ($urandom_range(3) == 0) cnt = rand_count();
            else cnt = COUNT_W'($urandom_range(0, 4));
            send_request(MODE_POP_MANY, rand_value(), rand_index(), cnt);
         end else if (pick < 97) begin
            send_request(MODE_SPARE_6, rand_value(), rand_index(), rand_count());
         end else begin
            send_request(MODE_SPARE_7, rand_value(), rand_index(), rand_count());
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      stack_result_type want;
      if (!reset && rsp_valid) begin
         checked_count++;
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: status %0d used %0d",
                   rsp_status, rsp_used_now);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_removed !== want.removed) begin
               $error("removed: expected %0d, got %0d", want.removed, rsp_removed);
               mismatch_count++;
            end
            if (rsp_used_now !== want.used_now) begin
               $error("used_now: expected %0d, got %0d", want.used_now, rsp_used_now);
               mismatch_count++;
            end
            if (rsp_capacity_now !== want.capacity_now) begin
               $error("capacity_now: expected %0d, got %0d",
                      want.capacity_now, rsp_capacity_now);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_refusals();
      test_basic_ops();
      test_capacity_sweep();
      test_random_traffic(RANDOM_ITEMS, 0);
      test_random_traffic(RANDOM_ITEMS, 79);
      test_random_traffic(RANDOM_ITEMS, 26);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d mismatches", request_count,
               checked_count, mismatch_count);
      $display("covered empty and full refusals, capacity grown to depth and back, random mixes");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
